[sv/sapc_pkg.sv]
// Shared types, constants and helpers of the page cache tag engine.
`default_nettype none
package sapc_pkg;

  localparam int unsigned WAYS = 16;
  localparam int unsigned WAY_BITS = 4;
  localparam int unsigned GROUP_COUNT_DEF = 1024;
  localparam int unsigned SLOT_BITS = 14;
  localparam logic [4:0] FD_BITS_RESET = 5'd10;
  localparam logic [31:0] HASH_SEED = 32'h0D15EA5E;
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [7:0] USE_MAX = 8'd254;
  localparam logic [15:0] REF_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_ACQUIRE = 3'd0,
    MODE_RETAIN  = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_FILL    = 3'd3,
    MODE_CLOSE   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_HIT_VALID   = 3'd0,
    ST_HIT_PENDING = 3'd1,
    ST_MISS_ALLOC  = 3'd2,
    ST_RETRY       = 3'd3,
    ST_DONE        = 3'd4,
    ST_BAD         = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [7:0]  use_cnt;
    logic [15:0] ref_cnt;
  } way_t;

  typedef struct packed {
    logic [WAYS-1:0]        valid;
    way_t [WAYS-1:0]        ways;
  } row_t;

  localparam int unsigned ROW_BITS = $bits(row_t);

  // Advance the reflected CRC by eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in);
    logic [31:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/sapc_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module sapc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[sv/sapc_hash.sv]
// Group index unit: CRC32C of the tag a byte per cycle, then remainder by group count.
`default_nettype none
module sapc_hash #(
  parameter int unsigned GROUP_COUNT = sapc_pkg::GROUP_COUNT_DEF,
  localparam int unsigned GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   tag,
  output logic               done,
  output logic [GW-1:0]      group
);

  localparam bit IS_POW2 = ((GROUP_COUNT & (GROUP_COUNT - 1)) == 0);
  localparam logic [GW-1:0] GMASK = GW'(GROUP_COUNT - 1);
  localparam logic [31:0] GDIV = 32'(GROUP_COUNT);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / GROUP_COUNT);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_CRC  = 4'b0010,
    H_MUL  = 4'b0100,
    H_MOD  = 4'b1000
  } hstate_t;

  // Seed the CRC with the tag
  function automatic logic [31:0] HASH_SEED_X(input logic [31:0] t);
    return sapc_pkg::HASH_SEED ^ t;
  endfunction

  hstate_t     state;
  logic [31:0] crc;
  logic [4:0]  cnt;
  logic [31:0] quot;
  logic [63:0] prod;
  logic [31:0] mod_diff;
  logic [31:0] crc_step;

  assign crc_step = sapc_pkg::crc_byte(crc);

  // Estimate the quotient by the reciprocal; it falls short by at most one
  always_comb begin
    prod     = {32'd0, crc} * {32'd0, RECIP};
    mod_diff = crc - 32'(quot * GDIV);
    if (mod_diff >= GDIV) begin
      mod_diff = mod_diff - GDIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (start) begin
            crc   <= HASH_SEED_X(tag);
            cnt   <= '0;
            state <= H_CRC;
          end
        end
        H_CRC: begin
          crc <= crc_step;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            cnt <= '0;
            if (IS_POW2) begin
              group <= crc_step[GW-1:0] & GMASK;
              done  <= 1'b1;
              state <= H_IDLE;
            end else begin
              state <= H_MUL;
            end
          end
        end
        H_MUL: begin
          quot  <= prod[63:32];
          state <= H_MOD;
        end
        H_MOD: begin
          group <= mod_diff[GW-1:0];
          done  <= 1'b1;
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/set_assoc_page_cache_tags.sv]
// Tag and replacement engine of a 16-way set-associative page cache.
// Acquire: CRC over the tag, plus multiply and remainder steps when GROUP_COUNT is not
// a power of two, then read, scan and write-back; a retry result skips the write-back.
// Retain, release and fill go through issue, load and write-back; close reads and rewrites every row.
// One item at a time; the next beat is taken the cycle after the result loads.
// After reset a clearing pass writes every row before input is taken.
`default_nettype none
module set_assoc_page_cache_tags #(
  parameter int unsigned GROUP_COUNT = sapc_pkg::GROUP_COUNT_DEF,
  localparam int unsigned GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [15:0] file_id,
  input  wire logic [30:0] page_number,
  input  wire logic [13:0] slot_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [13:0]      slot_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [GW-1:0] LAST_ROW = GW'(GROUP_COUNT - 1);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HASH  = 11'b00000000100,
    S_ISSUE = 11'b00000001000,
    S_LOAD  = 11'b00000010000,
    S_SCAN0 = 11'b00000100000,
    S_SCAN1 = 11'b00001000000,
    S_WR    = 11'b00010000000,
    S_CRD   = 11'b00100000000,
    S_CMOD  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t      state;
  logic [4:0]  fd_bits;
  logic [2:0]  cur_mode;
  logic [31:0] cur_tag;
  logic [31:0] cur_fdsh;
  logic [31:0] cur_himask;
  logic [3:0]  cur_way;
  logic [13:0] cur_slot;
  logic [GW-1:0] gid;
  logic [GW-1:0] idx;
  sapc_pkg::row_t row;
  logic [2:0]  res_status;
  logic [13:0] res_slot;
  logic [3:0]  best;
  logic [7:0]  hmin;
  logic        found;

  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, fd_bits} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fd_bits <= sapc_pkg::FD_BITS_RESET;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      fd_bits <= pwdata[4:0];
    end
  end

  // Decode the request at acceptance
  logic [4:0]  fb;
  logic [5:0]  shift;
  logic        fd_bad;
  logic        pno_bad;
  logic [31:0] fdsh;
  logic [31:0] himask;
  logic [31:0] slot_grp;
  logic        slot_bad;
  logic        accept;

  always_comb begin
    priority if (fd_bits == 5'd0) begin
      fb = 5'd1;
    end else if (fd_bits > 5'd16) begin
      fb = 5'd16;
    end else begin
      fb = fd_bits;
    end
    shift    = 6'd32 - {1'b0, fb};
    fd_bad   = (file_id == 16'd0) || ((file_id >> fb) != 16'd0);
    pno_bad  = (({1'b0, page_number}) >> shift) != 32'd0;
    fdsh     = {16'd0, file_id} << shift;
    himask   = 32'hFFFFFFFF << shift;
    slot_grp = {22'd0, slot_in[13:4]};
    slot_bad = slot_grp >= 32'(GROUP_COUNT);
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Group index unit
  logic          hash_start;
  logic          hash_done;
  logic [GW-1:0] hash_group;

  assign hash_start = accept && (mode == sapc_pkg::MODE_ACQUIRE) && !fd_bad && !pno_bad;

  sapc_hash #(.GROUP_COUNT(GROUP_COUNT)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .tag   (fdsh | {1'b0, page_number}),
    .done  (hash_done),
    .group (hash_group)
  );

  // Row memory
  logic                  ram_we;
  logic [GW-1:0]         ram_addr;
  sapc_pkg::row_t        ram_wdata;
  sapc_pkg::row_t        ram_rdata;
  sapc_pkg::row_t        close_row;

  always_comb begin
    close_row = ram_rdata;
    for (int w = 0; w < sapc_pkg::WAYS; w++) begin
      if ((ram_rdata.ways[w].tag & cur_himask) == cur_fdsh) begin
        close_row.ways[w].tag     = 32'd0;
        close_row.ways[w].use_cnt = 8'd0;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = gid;
    ram_wdata = row;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = idx;
        ram_wdata = '0;
      end
      S_CRD: ram_addr = idx;
      S_CMOD: begin
        ram_we    = 1'b1;
        ram_addr  = idx;
        ram_wdata = close_row;
      end
      S_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  sapc_ram #(.WIDTH(sapc_pkg::ROW_BITS), .DEPTH(GROUP_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Slot operations on the freshly read row
  sapc_pkg::row_t op_row;
  always_comb begin
    op_row = ram_rdata;
    unique case (cur_mode)
      sapc_pkg::MODE_RETAIN: begin
        if (ram_rdata.ways[cur_way].ref_cnt != sapc_pkg::REF_MAX) begin
          op_row.ways[cur_way].ref_cnt = ram_rdata.ways[cur_way].ref_cnt + 16'd1;
        end
      end
      sapc_pkg::MODE_RELEASE: begin
        if (ram_rdata.ways[cur_way].ref_cnt != 16'd0) begin
          op_row.ways[cur_way].ref_cnt = ram_rdata.ways[cur_way].ref_cnt - 16'd1;
        end
      end
      sapc_pkg::MODE_FILL: op_row.valid[cur_way] = 1'b1;
      default: ;
    endcase
  end

  // Hit lookup over all ways
  logic           hit;
  logic [3:0]     hit_way;
  sapc_pkg::row_t hit_row;
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = sapc_pkg::WAYS - 1; w >= 0; w--) begin
      if (row.ways[w].tag == cur_tag) begin
        hit     = 1'b1;
        hit_way = 4'(w);
      end
    end
    hit_row = row;
    if (row.ways[hit_way].use_cnt < sapc_pkg::USE_MAX) begin
      hit_row.ways[hit_way].use_cnt = row.ways[hit_way].use_cnt + 8'd1;
    end
    if (row.ways[hit_way].ref_cnt != sapc_pkg::REF_MAX) begin
      hit_row.ways[hit_way].ref_cnt = row.ways[hit_way].ref_cnt + 16'd1;
    end
  end

  // Victim scan, eight ways per cycle in rotated order
  logic [3:0] scan_best;
  logic [7:0] scan_hmin;
  logic       scan_found;
  always_comb begin
    logic [3:0] i;
    logic [3:0] base;
    base       = (state == S_SCAN0) ? 4'd0 : 4'd8;
    scan_best  = (state == S_SCAN0) ? cur_tag[3:0] : best;
    scan_hmin  = (state == S_SCAN0) ? 8'hFF : hmin;
    scan_found = (state == S_SCAN0) ? 1'b0 : found;
    for (int k = 0; k < 8; k++) begin
      i = cur_tag[3:0] + base + 4'(k);
      if (row.ways[i].use_cnt < scan_hmin && row.ways[i].ref_cnt == 16'd0) begin
        scan_best  = i;
        scan_hmin  = row.ways[i].use_cnt;
        scan_found = 1'b1;
      end
    end
  end

  sapc_pkg::row_t fill_row;
  always_comb begin
    fill_row = row;
    fill_row.ways[scan_best].tag     = cur_tag;
    fill_row.ways[scan_best].use_cnt = 8'd0;
    fill_row.ways[scan_best].ref_cnt = 16'd1;
    fill_row.valid[scan_best]        = 1'b0;
  end

  logic [13:0] gid_slot_base;
  assign gid_slot_base = 14'({{(32 - GW){1'b0}}, gid} << 4);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          idx <= idx + GW'(1);
          if (idx == LAST_ROW) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur_mode   <= mode;
            cur_tag    <= fdsh | {1'b0, page_number};
            cur_fdsh   <= fdsh;
            cur_himask <= himask;
            cur_way    <= slot_in[3:0];
            cur_slot   <= slot_in;
            gid        <= slot_grp[GW-1:0];
            idx        <= '0;
            res_status <= sapc_pkg::ST_BAD;
            res_slot   <= '0;
            priority case (mode)
              sapc_pkg::MODE_ACQUIRE: state <= (fd_bad || pno_bad) ? S_DONE : S_HASH;
              sapc_pkg::MODE_CLOSE:   state <= fd_bad ? S_DONE : S_CRD;
              sapc_pkg::MODE_RETAIN,
              sapc_pkg::MODE_RELEASE,
              sapc_pkg::MODE_FILL:    state <= slot_bad ? S_DONE : S_ISSUE;
              default:                state <= S_DONE;
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            gid   <= hash_group;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_LOAD;
        S_LOAD: begin
          row <= op_row;
          if (cur_mode == sapc_pkg::MODE_ACQUIRE) begin
            state <= S_SCAN0;
          end else begin
            res_status <= sapc_pkg::ST_DONE;
            res_slot   <= cur_slot;
            state      <= S_WR;
          end
        end
        S_SCAN0: begin
          if (hit) begin
            row        <= hit_row;
            res_status <= row.valid[hit_way] ? sapc_pkg::ST_HIT_VALID
                                             : sapc_pkg::ST_HIT_PENDING;
            res_slot   <= gid_slot_base | {10'd0, hit_way};
            state      <= S_WR;
          end else begin
            best  <= scan_best;
            hmin  <= scan_hmin;
            found <= scan_found;
            state <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (scan_found) begin
            row        <= fill_row;
            res_status <= sapc_pkg::ST_MISS_ALLOC;
            res_slot   <= gid_slot_base | {10'd0, scan_best};
            state      <= S_WR;
          end else begin
            res_status <= sapc_pkg::ST_RETRY;
            state      <= S_DONE;
          end
        end
        S_WR: state <= S_DONE;
        S_CRD: state <= S_CMOD;
        S_CMOD: begin
          idx <= idx + GW'(1);
          if (idx == LAST_ROW) begin
            res_status <= sapc_pkg::ST_DONE;
            state      <= S_DONE;
          end else begin
            state <= S_CRD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a finished result, drop a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      status    <= res_status;
      slot_out  <= res_slot;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
